// ----- rtl/sifc_pkg.sv -----
// shared types and codes for the sorted insert and floor search table
package sifc_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned IndexWidth = 7;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef logic signed [ValueWidth-1:0] value_t;
  typedef logic signed [IndexWidth-1:0] index_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic   insert;
    logic   load;
    logic   scan;
    value_t operand;
  } ctrl_t;

  // what a cell hands to its upper neighbor
  typedef struct packed {
    logic   valid;
    logic   shift;
    value_t value;
  } link_t;

endpackage

// ----- rtl/sifc_in_if.sv -----
// input channel carrying one command word
interface sifc_in_if import sifc_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   command;
  value_t item_value;
  value_t search_key;

  modport source (output valid, output command, output item_value, output search_key,
                  input ready);
  modport sink (input valid, input command, input item_value, input search_key,
                output ready);
endinterface

// ----- rtl/sifc_out_if.sv -----
// output channel carrying one result word
interface sifc_out_if import sifc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] status;
  index_t     floor_index;

  modport source (output valid, output status, output floor_index, input ready);
  modport sink (input valid, input status, input floor_index, output ready);
endinterface

// ----- rtl/sifc_cell.sv -----
// one table cell: entry, valid bit and query flag
module sifc_cell import sifc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  ctrl_t ctrl_i,
  input  link_t prev_i,
  output link_t link_o,
  input  logic  flag_i,
  output logic  flag_o
);

  value_t value_q;
  logic   valid_q;
  logic   flag_q;
  logic   greater;

  assign greater = valid_q && (value_q > ctrl_i.operand);

  assign link_o.valid = valid_q;
  assign link_o.shift = greater;
  assign link_o.value = value_q;
  assign flag_o       = flag_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.insert) begin
      if (prev_i.shift) begin
        value_q <= prev_i.value;
      end else if (greater || (!valid_q && prev_i.valid)) begin
        value_q <= ctrl_i.operand;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      flag_q  <= 1'b0;
    end else begin
      if (ctrl_i.insert && (prev_i.shift || prev_i.valid)) begin
        valid_q <= 1'b1;
      end
      if (ctrl_i.load) begin
        flag_q <= valid_q && (value_q <= ctrl_i.operand);
      end else if (ctrl_i.scan) begin
        flag_q <= flag_i;
      end
    end
  end

endmodule

// ----- rtl/sorted_insert_floor_search_core.sv -----
// sorted table of signed values with ordered insert and floor lookup
// insert: result registered on acceptance; one insert per cycle while results are taken
// query: the compare loads every cell's flag, then the flag chain drains one cell per cycle
//   until the first cell's flag clears, which gives floor_index
// reset clears the entry count, the scan state and all valid bits
// entries hold no reset value; only written cells are ever compared
module sorted_insert_floor_search_core import sifc_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input logic         clk_i,
  input logic         rst_ni,
  sifc_in_if.sink     in_s,
  sifc_out_if.source  out_m
);

  localparam int unsigned CntWidth = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ExtWidth = (CntWidth > IndexWidth) ? CntWidth : IndexWidth;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                state_q, state_d;
  logic [CntWidth-1:0] count_q, count_d;
  logic [CntWidth-1:0] scan_cnt_q, scan_cnt_d;
  logic                out_valid_q, out_valid_d;
  logic [1:0]          status_q, status_d;
  index_t              index_q, index_d;

  ctrl_t               ctrl;
  link_t               links [TABLE_DEPTH+1];
  logic                flags [TABLE_DEPTH+1];

  logic                in_acc;
  logic                out_free;
  logic                is_full;
  logic                is_empty;
  logic [ExtWidth-1:0] floor_ext;

  assign links[0]           = '{valid: 1'b1, shift: 1'b0, value: '0};
  assign flags[TABLE_DEPTH] = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    sifc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .prev_i (links[i]),
      .link_o (links[i+1]),
      .flag_i (flags[i+1]),
      .flag_o (flags[i])
    );
  end

  assign out_free   = !out_valid_q || out_m.ready;
  assign in_s.ready = (state_q == ST_IDLE) && out_free;
  assign in_acc     = in_s.valid && in_s.ready;
  assign is_full    = (count_q == CntWidth'(TABLE_DEPTH));
  assign is_empty   = (count_q == '0);
  assign floor_ext  = ExtWidth'(scan_cnt_q) - ExtWidth'(1);

  always_comb begin
    ctrl.insert  = in_acc && (in_s.command == CMD_INSERT) && !is_full;
    ctrl.load    = in_acc && (in_s.command == CMD_QUERY) && !is_empty;
    ctrl.scan    = (state_q == ST_SCAN) && flags[0];
    ctrl.operand = (in_s.command == CMD_QUERY) ? in_s.search_key : in_s.item_value;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_cnt_d  = scan_cnt_q;
    out_valid_d = out_valid_q && !out_m.ready;
    status_d    = status_q;
    index_d     = index_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_s.command == CMD_INSERT) begin
            out_valid_d = 1'b1;
            index_d     = '0;
            if (is_full) begin
              status_d = STATUS_FULL;
            end else begin
              status_d = STATUS_OK;
              count_d  = count_q + CntWidth'(1);
            end
          end else if (is_empty) begin
            out_valid_d = 1'b1;
            status_d    = STATUS_EMPTY;
            index_d     = '1;
          end else begin
            scan_cnt_d = '0;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (flags[0]) begin
          scan_cnt_d = scan_cnt_q + CntWidth'(1);
        end else if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = STATUS_OK;
          index_d     = index_t'(floor_ext[IndexWidth-1:0]);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_cnt_q  <= scan_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    index_q  <= index_d;
  end

  assign out_m.valid       = out_valid_q;
  assign out_m.status      = status_q;
  assign out_m.floor_index = index_q;

endmodule

// ----- tb/tb_top.sv -----
// testbench for the sorted insert and floor search table: queued driver, checking monitor
module tb_top;
  import sifc_pkg::*;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned NumRandom  = 1480;
  localparam int unsigned HoldAt     = 400;
  localparam int unsigned HoldLen    = 300;
  localparam int unsigned QuietTail  = 150;

  typedef struct {
    logic   command;
    value_t item_value;
    value_t search_key;
    bit     drain_first;
  } cmd_word_t;

  typedef struct {
    logic [1:0] status;
    index_t     floor_index;
  } result_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;

  sifc_in_if  in_ch ();
  sifc_out_if out_ch ();

  logic   drv_valid   = 1'b0;
  logic   drv_command = CMD_INSERT;
  value_t drv_item    = '0;
  value_t drv_key     = '0;
  logic   mon_ready   = 1'b0;

  assign in_ch.valid      = drv_valid;
  assign in_ch.command    = drv_command;
  assign in_ch.item_value = drv_item;
  assign in_ch.search_key = drv_key;
  assign out_ch.ready     = mon_ready;

  sorted_insert_floor_search_core #(
    .TABLE_DEPTH(TableDepth)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_s  (in_ch),
    .out_m (out_ch)
  );

  // shadow of the table contents
  value_t      table_model [TableDepth];
  int unsigned table_fill = 0;

  cmd_word_t    word_q[$];
  result_word_t pending_results[$];
  value_t       val_pool [8];
  int unsigned  errors = 0;

  function automatic int unsigned count_at_most(value_t v);
    int unsigned n;
    n = 0;
    for (int unsigned i = 0; i < table_fill; i++) begin
      if (table_model[i] <= v) n++;
    end
    return n;
  endfunction

  function automatic result_word_t predict_result(cmd_word_t w);
    result_word_t r;
    int unsigned  pos;
    if (w.command == CMD_INSERT) begin
      r.floor_index = '0;
      if (table_fill >= TableDepth) begin
        r.status = STATUS_FULL;
      end else begin
        pos = count_at_most(w.item_value);
        for (int unsigned i = table_fill; i > pos; i--) table_model[i] = table_model[i-1];
        table_model[pos] = w.item_value;
        table_fill++;
        r.status = STATUS_OK;
      end
    end else if (table_fill == 0) begin
      r.status      = STATUS_EMPTY;
      r.floor_index = index_t'(-1);
    end else begin
      r.status      = STATUS_OK;
      r.floor_index = index_t'(int'(count_at_most(w.search_key)) - 1);
    end
    return r;
  endfunction

  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0:       return value_t'(32'h8000_0000);
      1:       return value_t'(32'h7fff_ffff);
      2:       return $urandom_range(0, 1) ? value_t'(0) : value_t'(-1);
      3, 4, 5: return val_pool[$urandom_range(0, 7)];
      default: return value_t'($urandom);
    endcase
  endfunction

  function automatic value_t pick_key();
    case ($urandom_range(0, 9))
      0:       return value_t'(32'h8000_0000);
      1:       return value_t'(32'h7fff_ffff);
      2, 3:    return val_pool[$urandom_range(0, 7)];
      4:       return val_pool[$urandom_range(0, 7)] + value_t'(1);
      5:       return val_pool[$urandom_range(0, 7)] - value_t'(1);
      default: return value_t'($urandom);
    endcase
  endfunction

  task automatic push_word(logic cmd, value_t v, value_t k, bit drain);
    cmd_word_t w;
    w.command     = cmd;
    w.item_value  = v;
    w.search_key  = k;
    w.drain_first = drain;
    word_q.push_back(w);
  endtask

  // driver
  cmd_word_t   cur_word;
  bit          offering;
  int unsigned send_gap    = 0;
  int unsigned words_taken = 0;
  bit          quiet_tail  = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      offering = drv_valid;
      if (drv_valid && in_ch.ready) begin
        pending_results.push_back(predict_result(cur_word));
        words_taken <= words_taken + 1;
        offering = 1'b0;
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (word_q.size() != 0 &&
                     !(word_q[0].drain_first && pending_results.size() != 0)) begin
          cur_word = word_q.pop_front();
          offering = 1'b1;
          if (!quiet_tail && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 18);
        end
      end
      drv_valid   <= offering;
      drv_command <= cur_word.command;
      drv_item    <= cur_word.item_value;
      drv_key     <= cur_word.search_key;
      quiet_tail  <= (word_q.size() < QuietTail);
    end
  end

  // long receiver hold-off once the run is under way
  int unsigned hold_cycles = 0;
  bit          hold_done   = 1'b0;
  logic        hold_on;

  assign hold_on = (words_taken >= HoldAt) && !hold_done;

  always @(posedge clk_i) begin
    if (rst_ni && hold_on) begin
      if (hold_cycles == HoldLen - 1) hold_done <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end
  end

  // monitor
  result_word_t want;
  int unsigned  recv_stall = 0;
  bit           take_next;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      mon_ready <= 1'b0;
    end else begin
      if (out_ch.valid && mon_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected word status %0d floor_index %0d", $time,
                   out_ch.status, out_ch.floor_index);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_ch.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_ch.status);
            errors++;
          end
          if (out_ch.floor_index !== want.floor_index) begin
            $display("%0t: floor_index expected %0d actual %0d", $time,
                     want.floor_index, out_ch.floor_index);
            errors++;
          end
        end
      end
      if (hold_on) begin
        take_next = 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        take_next = 1'b0;
      end else begin
        take_next = 1'b1;
        if (!quiet_tail && $urandom_range(0, 9) == 0) recv_stall = $urandom_range(1, 18);
      end
      mon_ready <= take_next;
    end
  end

  initial begin
    int unsigned ins_pct;
    logic        cmd;
    for (int i = 0; i < 8; i++) val_pool[i] = value_t'($urandom);

    // empty table, less than all, duplicates, extremes
    push_word(CMD_QUERY,  value_t'($urandom), 0, 1'b0);
    push_word(CMD_QUERY,  value_t'($urandom), value_t'(32'h7fff_ffff), 1'b0);
    push_word(CMD_INSERT, 0, value_t'($urandom), 1'b0);
    push_word(CMD_QUERY,  value_t'($urandom), -5, 1'b0);
    push_word(CMD_QUERY,  value_t'($urandom), 0, 1'b0);
    push_word(CMD_INSERT, value_t'(32'h8000_0000), value_t'($urandom), 1'b0);
    push_word(CMD_INSERT, value_t'(32'h7fff_ffff), value_t'($urandom), 1'b0);
    push_word(CMD_INSERT, 0, value_t'($urandom), 1'b0);
    push_word(CMD_INSERT, 0, value_t'($urandom), 1'b0);
    push_word(CMD_QUERY,  value_t'($urandom), 0, 1'b0);
    push_word(CMD_QUERY,  value_t'($urandom), -1, 1'b0);
    push_word(CMD_QUERY,  value_t'($urandom), value_t'(32'h8000_0000), 1'b0);
    push_word(CMD_QUERY,  value_t'($urandom), value_t'(32'h7fff_ffff), 1'b0);
    push_word(CMD_QUERY,  value_t'($urandom), value_t'(32'h7fff_fffe), 1'b0);
    push_word(CMD_INSERT, -1, value_t'($urandom), 1'b0);
    push_word(CMD_INSERT, value_t'(32'h7fff_ffff), value_t'($urandom), 1'b0);
    push_word(CMD_QUERY,  value_t'($urandom), value_t'(32'h7fff_ffff), 1'b0);
    push_word(CMD_QUERY,  value_t'($urandom), 1, 1'b0);

    // fill with a mix of inserts and lookups, then mostly lookups on the full table
    for (int unsigned n = 0; n < NumRandom; n++) begin
      ins_pct = (n < 300) ? 50 : 15;
      cmd = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_QUERY;
      push_word(cmd, pick_value(), pick_key(), (n == 0) || (n == 800));
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (word_q.size() != 0 || drv_valid) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TableDepth + 16) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #3_200_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
